// ===== rtl/eqp_pkg.sv =====
// ----------------------------------------------------------------------------
// eqp_pkg
// Shared types and constants for the ellipse quadrant point generator.
// ----------------------------------------------------------------------------
package eqp_pkg;
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int OFS_BITS = RADIUS_BITS;
  // (2n-1)^2 * a^2 and 4 b^2 (a^2 - t^2) both fit in 4*R+2 bits
  localparam int PROD_BITS = 4 * RADIUS_BITS + 2;
  localparam int SQ_BITS   = 2 * RADIUS_BITS + 2;
  localparam int QCNT_BITS = $clog2(RADIUS_BITS + 1);

  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd3;

  typedef logic [RADIUS_BITS-1:0] radius_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  // classified job handed from front to back
  typedef struct packed {
    radius_t a;
    radius_t b;
    radius_t t;
    logic    wide;
  } job_t;

  typedef struct packed {
    logic [OFS_BITS-1:0] dx;
    logic [OFS_BITS-1:0] dy;
  } ofs_t;

  typedef struct packed {
    coord_t     point_x;
    coord_t     point_y;
    logic [1:0] quadrant;
    logic       last;
  } point_t;
endpackage

// ===== rtl/eqp_if.sv =====
// ----------------------------------------------------------------------------
// eqp_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface eqp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/eqp_front.sv =====
// ----------------------------------------------------------------------------
// eqp_front
// Accepts steps, picks major/minor radius, clamps step, feeds a 2-entry queue.
// ----------------------------------------------------------------------------
module eqp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eqp_pkg::radius_t     in_step,
  input  eqp_pkg::radius_t     radius_x,
  input  eqp_pkg::radius_t     radius_y,
  output logic                 job_valid,
  input  logic                 job_ready,
  output eqp_pkg::job_t        job
);
  import eqp_pkg::*;

  job_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  job_t       cls;
  logic       push, pop;

  always_comb begin
    cls.wide = radius_x >= radius_y;
    cls.a    = cls.wide ? radius_x : radius_y;
    cls.b    = cls.wide ? radius_y : radius_x;
    cls.t    = (in_step > cls.a) ? cls.a : in_step;
  end

  assign in_ready  = cnt_r != 2'd2;
  assign push      = in_valid && in_ready;
  assign job_valid = cnt_r != 2'd0;
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/eqp_root.sv =====
// ----------------------------------------------------------------------------
// eqp_root
// Bit-serial search for the rounded minor offset, one bit per cycle.
// ----------------------------------------------------------------------------
module eqp_root (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  eqp_pkg::job_t  job,
  output logic           ofs_valid,
  input  logic           ofs_ready,
  output eqp_pkg::ofs_t  ofs
);
  import eqp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_PREP = 4'b0010, S_SRCH = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t                 state_r;
  job_t                   job_r;
  logic [SQ_BITS-1:0]     a2_r, rr_r, b4_r;
  logic [PROD_BITS-1:0]   rhs_r;
  logic [OFS_BITS-1:0]    n_r;
  logic [SQ_BITS-1:0]     sq_r;
  logic [QCNT_BITS-1:0]   bit_r;
  logic [OFS_BITS-1:0]    cand;
  logic [SQ_BITS-1:0]     csq;
  logic [SQ_BITS-1:0]     k2;
  logic [PROD_BITS-1:0]   lhs;
  logic                   prep_phase_r;

  // candidate with the current bit set; accepted if (2c-1)^2 a^2 <= rhs and c <= b
  assign cand = n_r | (OFS_BITS'(1) << bit_r);
  // c^2 built from n^2 by shifts, the bits below the current one are still clear
  assign csq  = sq_r + (SQ_BITS'(n_r) << (bit_r + QCNT_BITS'(1)))
              + (SQ_BITS'(1) << {bit_r, 1'b0});
  assign k2   = (csq << 2) - (SQ_BITS'(cand) << 2) + SQ_BITS'(1);
  assign lhs  = PROD_BITS'(k2) * PROD_BITS'(a2_r);

  assign job_ready = state_r == S_IDLE;
  assign ofs_valid = state_r == S_DONE;
  assign ofs.dx = job_r.wide ? job_r.t : n_r;
  assign ofs.dy = job_r.wide ? n_r : job_r.t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            n_r <= '0;
            sq_r <= '0;
            prep_phase_r <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          if (!prep_phase_r) begin
            a2_r <= SQ_BITS'(job_r.a * job_r.a);
            rr_r <= SQ_BITS'(job_r.t * job_r.t);
            b4_r <= SQ_BITS'({job_r.b, 1'b0} * {job_r.b, 1'b0});
            prep_phase_r <= 1'b1;
          end else begin
            rhs_r <= PROD_BITS'(b4_r) * PROD_BITS'(a2_r - rr_r);
            bit_r <= QCNT_BITS'(OFS_BITS - 1);
            state_r <= (job_r.a == '0) ? S_DONE : S_SRCH;
          end
        end
        S_SRCH: begin
          if (cand <= job_r.b && lhs <= rhs_r) begin
            n_r <= cand;
            sq_r <= csq;
          end
          if (bit_r == '0) state_r <= S_DONE;
          else bit_r <= bit_r - QCNT_BITS'(1);
        end
        S_DONE: if (ofs_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/eqp_emit.sv =====
// ----------------------------------------------------------------------------
// eqp_emit
// Emits the four mirrored, saturated points of one offset pair.
// ----------------------------------------------------------------------------
module eqp_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ofs_valid,
  output logic              ofs_ready,
  input  eqp_pkg::ofs_t     ofs,
  input  eqp_pkg::coord_t   center_x,
  input  eqp_pkg::coord_t   center_y,
  output logic              out_valid,
  input  logic              out_ready,
  output eqp_pkg::point_t   out_data
);
  import eqp_pkg::*;

  localparam int SUM_BITS = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 2;

  ofs_t       ofs_r;
  logic       busy_r;
  logic [1:0] q_r;
  logic       valid_r;
  point_t     pt_r;
  point_t     pt;
  logic       adv;

  function automatic coord_t sat(input coord_t c, input logic [OFS_BITS-1:0] d,
                                 input logic neg);
    logic signed [SUM_BITS-1:0] s;
    s = neg ? SUM_BITS'(c) - $signed(SUM_BITS'(d)) : SUM_BITS'(c) + $signed(SUM_BITS'(d));
    if (s > SUM_BITS'(2047)) return coord_t'(2047);
    if (s < -SUM_BITS'(2048)) return coord_t'(-2048);
    return coord_t'(s);
  endfunction

  assign pt.point_x  = sat(center_x, ofs_r.dx, q_r[1]);
  assign pt.point_y  = sat(center_y, ofs_r.dy, q_r[0]);
  assign pt.quadrant = q_r;
  assign pt.last     = q_r == 2'd3;

  assign adv       = busy_r && (!valid_r || out_ready);
  assign ofs_ready = !busy_r;
  assign out_valid = valid_r;
  assign out_data  = pt_r;

  always_ff @(posedge clk) begin
    if (ofs_valid && ofs_ready) ofs_r <= ofs;
    if (adv) pt_r <= pt;
    if (!rst_n) begin
      busy_r <= 1'b0; q_r <= 2'd0; valid_r <= 1'b0;
    end else begin
      if (ofs_valid && ofs_ready) begin
        busy_r <= 1'b1; q_r <= 2'd0;
      end else if (adv) begin
        q_r <= q_r + 2'd1;
        if (q_r == 2'd3) busy_r <= 1'b0;
      end
      if (adv) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end
endmodule

// ===== rtl/ellipse_quadrant_points.sv =====
// ----------------------------------------------------------------------------
// ellipse_quadrant_points
// Steps along the major axis of an ellipse and emits four mirrored points.
// ----------------------------------------------------------------------------
// Usage: write radius_x, radius_y, center_x, center_y through the cfg port
// (index 0..3) while idle; reset values are radii 1, centre 0.
// Input channel in_*: one step index per transfer. Output channel out_*:
// four points per step, quadrants 0..3 in order, last set on the fourth.
// Front classifies the step and clamps it to the major radius, a two-entry
// queue holds the jobs, the back end finds the minor offset one bit per
// cycle with a 42-bit compare of two multiplier products, then an emitter
// saturates and sends the points.
// The bit-serial offset search takes one job at a time and sets the
// throughput; the emitter overlaps it, sending the points of one step
// while the next offset is searched.
// Reset is synchronous, active low, and clears all queues and states.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops, nothing is lost.
// ----------------------------------------------------------------------------
module ellipse_quadrant_points (
  input  logic                               clk,
  input  logic                               rst_n,
  eqp_if.sink                                in_ch,
  eqp_if.source                              out_ch,
  input  logic                               cfg_we,
  input  logic [eqp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [eqp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import eqp_pkg::*;

  radius_t rx_r, ry_r;
  coord_t  cx_r, cy_r;
  logic    job_valid, job_ready, ofs_valid, ofs_ready;
  job_t    job;
  ofs_t    ofs;
  point_t  pt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= radius_t'(1); ry_r <= radius_t'(1); cx_r <= '0; cy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_X: rx_r <= cfg_data[RADIUS_BITS-1:0];
        REG_RADIUS_Y: ry_r <= cfg_data[RADIUS_BITS-1:0];
        REG_CENTER_X: cx_r <= coord_t'(cfg_data);
        REG_CENTER_Y: cy_r <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  eqp_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_step(in_ch.data), .radius_x(rx_r), .radius_y(ry_r),
    .job_valid, .job_ready, .job
  );

  eqp_root u_root (
    .clk, .rst_n, .job_valid, .job_ready, .job, .ofs_valid, .ofs_ready, .ofs
  );

  eqp_emit u_emit (
    .clk, .rst_n, .ofs_valid, .ofs_ready, .ofs, .center_x(cx_r), .center_y(cy_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(pt)
  );

  assign out_ch.data = pt;

  // at least one offset stays within its radius (the minor offset never exceeds the minor radius)
  a_ofs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ofs_valid |-> (ofs.dx <= rx_r || ofs.dy <= ry_r))
    else $error("offset beyond radius");

  // quadrant 3 always carries last
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pt.last == (pt.quadrant == 2'd3)))
    else $error("last flag mismatch");

  // a stalled point stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(pt))
    else $error("output changed under stall");
endmodule
